// ===== hdl/sc3_pkg.sv =====
package sc3_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int WIN_N       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COEF_W      = 8;
    localparam int KROW_W      = KERNEL_SIZE * COEF_W;
    localparam int STRIDE_W    = 3;
    localparam int DIM_W       = 11;
    localparam int ROW_W       = 10;
    localparam int IDX_W       = 10;
    localparam int SUM_W       = 19;
    localparam int MIN_DIM     = 3;
    localparam int MAX_HEIGHT  = 1024;
    localparam int DEFAULT_DIM = 1024;

    // reciprocal multiply for the small stride divider
    localparam int RECIP_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_BOT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd5;

    typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] t_kernel;

    // floor((2^16 - 1) / s); one correction step after the multiply fixes the quotient
    function automatic logic [RECIP_W-1:0] recip(input logic [STRIDE_W-1:0] s);
        logic [RECIP_W-1:0] m;
        case (s)
            3'd2:    m = 16'd32767;
            3'd3:    m = 16'd21845;
            3'd4:    m = 16'd16383;
            3'd5:    m = 16'd13107;
            3'd6:    m = 16'd10922;
            3'd7:    m = 16'd9362;
            default: m = 16'd65535;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/sc3_queue.sv =====
module sc3_queue #(
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_data,
    output logic                     o_empty,
    output logic [sc3_pkg::QCNT_W-1:0] o_count
);
    import sc3_pkg::*;

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ===== hdl/sc3_front.sv =====
module sc3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int CMP_W = (COL_W + 1 > sc3_pkg::DIM_W) ? COL_W + 1 : sc3_pkg::DIM_W,
    localparam int JOB_W = sc3_pkg::WIN_N * PIXEL_BITS + sc3_pkg::ROW_W + COL_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [PIXEL_BITS-1:0] i_pixel,
    input  logic [CMP_W-1:0]             i_w_eff,
    input  logic [sc3_pkg::DIM_W-1:0]    i_h_eff,
    input  logic [sc3_pkg::QCNT_W-1:0]   i_q_count,
    output logic                         o_q_push,
    output logic [JOB_W-1:0]             o_q_data
);
    import sc3_pkg::*;

    typedef struct packed {
        logic [WIN_N-1:0][PIXEL_BITS-1:0] win;
        logic [ROW_W-1:0]                 row;
        logic [COL_W-1:0]                 col;
    } t_job;

    logic [COL_W-1:0]                 r_col;
    logic [ROW_W-1:0]                 r_row;
    logic [COL_W-1:0]                 n_col;
    logic [ROW_W-1:0]                 n_row;
    logic                             r_s1_valid;
    logic [PIXEL_BITS-1:0]            r_s1_px;
    logic [COL_W-1:0]                 r_s1_col;
    logic [ROW_W-1:0]                 r_s1_row;
    logic [2*PIXEL_BITS-1:0]          r_rd;
    logic [2*PIXEL_BITS-1:0]          r_line_mem [MAX_WIDTH];
    logic [WIN_N-1:0][PIXEL_BITS-1:0] r_win;
    logic [WIN_N-1:0][PIXEL_BITS-1:0] n_win;

    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [DIM_W-1:0]  row_pre;
    logic [DIM_W-1:0]  row_inc;
    logic [CMP_W-1:0]  col_inc;
    logic [QCNT_W:0]   occ;
    logic              accept;
    logic [PIXEL_BITS-1:0] rd_top;
    logic [PIXEL_BITS-1:0] rd_mid;
    t_job              job;

    // the beat in stage 1 has not reached the queue yet, so count it as taken
    assign occ    = {1'b0, i_q_count} + {{QCNT_W{1'b0}}, r_s1_valid};
    assign o_full = (occ >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept = i_push && !o_full;

    // a counter left past the size by a new width or height restarts first
    always_comb begin
        if (CMP_W'(r_col) >= i_w_eff) begin
            cur_col = '0;
            row_pre = DIM_W'(r_row) + DIM_W'(1);
        end else begin
            cur_col = r_col;
            row_pre = DIM_W'(r_row);
        end
        cur_row = (row_pre >= i_h_eff) ? '0 : row_pre[ROW_W-1:0];
        col_inc = CMP_W'(cur_col) + CMP_W'(1);
        row_inc = DIM_W'(cur_row) + DIM_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (accept) begin
            if (col_inc >= i_w_eff) begin
                n_col = '0;
                n_row = (row_inc >= i_h_eff) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
                n_row = cur_row;
            end
        end
    end

    // line entry: upper half is the row above, lower half two rows above
    assign rd_top = r_rd[PIXEL_BITS-1:0];
    assign rd_mid = r_rd[2*PIXEL_BITS-1:PIXEL_BITS];

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                n_win[i*KERNEL_SIZE+j] = r_win[i*KERNEL_SIZE+j+1];
            end
        end
        n_win[KERNEL_SIZE-1]   = rd_top;
        n_win[2*KERNEL_SIZE-1] = rd_mid;
        n_win[WIN_N-1]         = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
        end
    end

    // read in the accept cycle, write back in the cycle after; a row is at least
    // three columns so the two never hit the same entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= i_pixel;
            r_s1_col <= cur_col;
            r_s1_row <= cur_row;
            r_rd     <= r_line_mem[cur_col];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= {r_s1_px, rd_mid};
            r_win                <= n_win;
        end
    end

    always_comb begin
        job.win = n_win;
        job.row = r_s1_row;
        job.col = r_s1_col;
    end

    assign o_q_push = r_s1_valid && (r_s1_row >= ROW_W'(2)) && (r_s1_col >= COL_W'(2));
    assign o_q_data = job;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (i_q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("window beat pushed into a full queue");

endmodule

// ===== hdl/sc3_back.sv =====
module sc3_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int CMP_W = (COL_W + 1 > sc3_pkg::DIM_W) ? COL_W + 1 : sc3_pkg::DIM_W,
    localparam int JOB_W = sc3_pkg::WIN_N * PIXEL_BITS + sc3_pkg::ROW_W + COL_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [JOB_W-1:0]                  i_q_data,
    input  logic                              i_q_empty,
    output logic                              o_q_pop,
    input  sc3_pkg::t_kernel                  i_kernel,
    input  logic [sc3_pkg::STRIDE_W-1:0]      i_stride,
    input  logic [CMP_W-1:0]                  i_w_eff,
    input  logic [sc3_pkg::DIM_W-1:0]         i_h_eff,
    input  logic                              i_pop,
    output logic                              o_valid,
    output logic signed [sc3_pkg::SUM_W-1:0]  o_conv_sum,
    output logic [sc3_pkg::IDX_W-1:0]         o_out_row,
    output logic [sc3_pkg::IDX_W-1:0]         o_out_col,
    output logic                              o_frame_last
);
    import sc3_pkg::*;

    localparam int PROD_W = PIXEL_BITS + COEF_W;
    localparam int ACC_W  = (PIXEL_BITS + 12 > SUM_W) ? PIXEL_BITS + 12 : SUM_W;
    localparam int PM_W   = CMP_W + RECIP_W;
    // lanes: output row, output column, last row, last column
    localparam int DIV_N  = 4;

    typedef struct packed {
        logic [WIN_N-1:0][PIXEL_BITS-1:0] win;
        logic [ROW_W-1:0]                 row;
        logic [COL_W-1:0]                 col;
    } t_job;

    t_job                                job;
    logic                                en;
    logic [DIV_N-1:0][CMP_W-1:0]         x;
    logic signed [PROD_W-1:0]            prod [WIN_N];

    logic                                r_v1;
    logic [STRIDE_W-1:0]                 r_s1_stride;
    logic [DIV_N-1:0][CMP_W-1:0]         r_x;
    logic [DIV_N-1:0][PM_W-1:0]          r_pm;
    logic signed [PROD_W-1:0]            r_prod [WIN_N];

    logic [DIV_N-1:0][CMP_W-1:0]         q;
    logic [DIV_N-1:0][STRIDE_W-1:0]      rem;
    logic signed [ACC_W-1:0]             rsum [KERNEL_SIZE];

    logic                                r_v2;
    logic [STRIDE_W-1:0]                 r_s2_stride;
    logic [DIV_N-1:0][CMP_W-1:0]         r_q;
    logic [DIV_N-1:0][STRIDE_W-1:0]      r_rem;
    logic signed [ACC_W-1:0]             r_rsum [KERNEL_SIZE];

    logic signed [ACC_W-1:0]             total;
    logic                                emit;

    logic                                r_out_valid;
    logic signed [SUM_W-1:0]             r_out_sum;
    logic [IDX_W-1:0]                    r_out_row;
    logic [IDX_W-1:0]                    r_out_col;
    logic                                r_out_last;

    assign job     = t_job'(i_q_data);
    assign en      = !r_out_valid || i_pop;
    assign o_q_pop = en && !i_q_empty;

    // stage 1: nine products, reciprocal multiplies
    assign x[0] = CMP_W'(job.row) - CMP_W'(2);
    assign x[1] = CMP_W'(job.col) - CMP_W'(2);
    assign x[2] = CMP_W'(i_h_eff) - CMP_W'(3);
    assign x[3] = i_w_eff - CMP_W'(3);

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                prod[i*KERNEL_SIZE+j] = $signed(job.win[i*KERNEL_SIZE+j])
                                      * $signed(i_kernel[i][j*COEF_W +: COEF_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_stride <= i_stride;
            for (int k = 0; k < DIV_N; k++) begin
                r_x[k]  <= x[k];
                r_pm[k] <= PM_W'(x[k]) * PM_W'(recip(i_stride));
            end
            for (int k = 0; k < WIN_N; k++) begin
                r_prod[k] <= prod[k];
            end
        end
    end

    // stage 2: quotient correction, row sums
    always_comb begin
        logic [CMP_W-1:0] q0;
        logic [CMP_W-1:0] rem_full;
        logic [CMP_W-1:0] s_ext;
        s_ext = CMP_W'(r_s1_stride);
        for (int k = 0; k < DIV_N; k++) begin
            q0       = r_pm[k][PM_W-1:RECIP_W];
            rem_full = r_x[k] - CMP_W'(q0 * s_ext);
            if (rem_full >= s_ext) begin
                q[k]   = q0 + CMP_W'(1);
                rem[k] = STRIDE_W'(rem_full - s_ext);
            end else begin
                q[k]   = q0;
                rem[k] = rem_full[STRIDE_W-1:0];
            end
        end
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            rsum[i] = ACC_W'(r_prod[i*KERNEL_SIZE])
                    + ACC_W'(r_prod[i*KERNEL_SIZE+1])
                    + ACC_W'(r_prod[i*KERNEL_SIZE+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_stride <= r_s1_stride;
            r_q         <= q;
            r_rem       <= rem;
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                r_rsum[i] <= rsum[i];
            end
        end
    end

    // stage 3: final sum, stride filter, result register
    assign total = r_rsum[0] + r_rsum[1] + r_rsum[2];
    assign emit  = (r_rem[0] == '0) && (r_rem[1] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= o_q_pop;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_sum  <= total[SUM_W-1:0];
            r_out_row  <= r_q[0][IDX_W-1:0];
            r_out_col  <= r_q[1][IDX_W-1:0];
            r_out_last <= (r_q[0] == r_q[2]) && (r_q[1] == r_q[3]);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_conv_sum   = r_out_sum;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_frame_last = r_out_last;

    a_rem_below_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_rem[0] < r_s2_stride) && (r_rem[1] < r_s2_stride)
              && (r_rem[2] < r_s2_stride) && (r_rem[3] < r_s2_stride))
        else $error("stride divider remainder not reduced");

endmodule

// ===== hdl/strided_conv2d_3x3_core.sv =====
// 3x3 valid correlation over a raster pixel stream, with stride.
// Input: one signed pixel per beat, raster order, taken when push is high
// and full is low. Output: one beat per window whose top-left corner sits on
// a multiple of the stride in row and column; the beat is on the result ports
// while empty is low and is taken when pop is high.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
// (kernel rows, stride, width, height); write only while no pixel is in flight.
// Throughput: one pixel per cycle while full is low, set by the line store and
// the nine parallel multipliers. A result passes the front stage register, the
// window queue and back stages 1 to 3 on its way to the ports.
// Reset clears the row/column counters, the pipeline and the result register,
// and restores kernel 0, stride 1, 1024 x 1024; the line store is not cleared,
// the first two rows of a frame only fill it.
// When the receiver stalls the result holds, the back pipeline freezes, the
// 4-entry window queue fills and full rises; nothing is dropped.
module strided_conv2d_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [PIXEL_BITS-1:0]          i_pixel,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [sc3_pkg::SUM_W-1:0]      o_conv_sum,
    output logic [sc3_pkg::IDX_W-1:0]             o_out_row,
    output logic [sc3_pkg::IDX_W-1:0]             o_out_col,
    output logic                                  o_frame_last,
    input  logic                                  i_cfg_wr_en,
    input  logic [sc3_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sc3_pkg::KROW_W-1:0]            i_cfg_wdata
);
    import sc3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int JOB_W = WIN_N * PIXEL_BITS + ROW_W + COL_W;

    t_kernel           r_kernel;
    logic [STRIDE_W-1:0] r_stride;
    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;

    logic [STRIDE_W-1:0] s_eff;
    logic [CMP_W-1:0]  w_ext;
    logic [CMP_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;

    logic              q_push;
    logic [JOB_W-1:0]  q_wdata;
    logic              q_pop;
    logic [JOB_W-1:0]  q_rdata;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;
    logic              out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel       <= '0;
            r_stride       <= STRIDE_W'(1);
            r_image_width  <= DIM_W'(DEFAULT_DIM);
            r_image_height <= DIM_W'(DEFAULT_DIM);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_KROW_TOP:   r_kernel[0]    <= i_cfg_wdata;
                REG_KROW_MID:   r_kernel[1]    <= i_cfg_wdata;
                REG_KROW_BOT:   r_kernel[2]    <= i_cfg_wdata;
                REG_STRIDE:     r_stride       <= i_cfg_wdata[STRIDE_W-1:0];
                REG_IMG_WIDTH:  r_image_width  <= i_cfg_wdata[DIM_W-1:0];
                REG_IMG_HEIGHT: r_image_height <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stride 0 acts as 1; sizes clamp to the supported range
    always_comb begin
        s_eff = (r_stride == '0) ? STRIDE_W'(1) : r_stride;
        w_ext = CMP_W'(r_image_width);
        if (w_ext < CMP_W'(MIN_DIM)) begin
            w_eff = CMP_W'(MIN_DIM);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_image_height < DIM_W'(MIN_DIM)) begin
            h_eff = DIM_W'(MIN_DIM);
        end else if (r_image_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_image_height;
        end
    end

    sc3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_pixel   (i_pixel),
        .i_w_eff   (w_eff),
        .i_h_eff   (h_eff),
        .i_q_count (q_count),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    sc3_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    sc3_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_data     (q_rdata),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_kernel     (r_kernel),
        .i_stride     (s_eff),
        .i_w_eff      (w_eff),
        .i_h_eff      (h_eff),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_conv_sum   (o_conv_sum),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last)
    );

    assign empty = !out_valid;

endmodule

// ===== dv/conv_window_checker.sv =====
`timescale 1ns / 1ps

module conv_window_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic signed [7:0]                  i_pixel,
    input  logic                               i_empty,
    input  logic                               i_pop,
    input  logic signed [sc3_pkg::SUM_W-1:0]   i_conv_sum,
    input  logic [sc3_pkg::IDX_W-1:0]          i_out_row,
    input  logic [sc3_pkg::IDX_W-1:0]          i_out_col,
    input  logic                               i_frame_last,
    input  logic                               i_cfg_wr_en,
    input  logic [sc3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sc3_pkg::KROW_W-1:0]         i_cfg_wdata,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);

    import sc3_pkg::*;

    typedef struct {
        logic signed [SUM_W-1:0] conv_sum;
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic                    frame_last;
    } t_conv_beat;

    t_conv_beat window_sums_q[$];

    logic signed [7:0]   line_top [MAX_WIDTH];
    logic signed [7:0]   line_mid [MAX_WIDTH];
    logic signed [7:0]   win [KERNEL_SIZE][KERNEL_SIZE];
    logic [KROW_W-1:0]   kernel_rows [KERNEL_SIZE];
    logic [STRIDE_W-1:0] stride_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    int                  col_cnt;
    int                  row_cnt;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    task automatic slide_window(input logic signed [7:0] px);
        int w, h, s, c, r, acc;
        logic signed [7:0] upper, middle, coef;
        t_conv_beat beat;

        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        s = (stride_reg == 0) ? 1 : int'(stride_reg);

        // counters left past the size by a register change wrap first
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
            row_cnt = 0;
        c = col_cnt;
        r = row_cnt;

        upper = line_top[c];
        middle = line_mid[c];
        line_top[c] = middle;
        line_mid[c] = px;

        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE - 1; j++)
                win[i][j] = win[i][j+1];
        end
        win[0][KERNEL_SIZE-1] = upper;
        win[1][KERNEL_SIZE-1] = middle;
        win[2][KERNEL_SIZE-1] = px;

        if (r >= 2 && c >= 2 && (r - 2) % s == 0 && (c - 2) % s == 0) begin
            acc = 0;
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                for (int j = 0; j < KERNEL_SIZE; j++) begin
                    coef = kernel_rows[i][COEF_W*j +: COEF_W];
                    acc = acc + win[i][j] * coef;
                end
            end
            beat.conv_sum = acc[SUM_W-1:0];
            beat.out_row = IDX_W'((r - 2) / s);
            beat.out_col = IDX_W'((c - 2) / s);
            beat.frame_last = ((r - 2) / s == (h - 3) / s) && ((c - 2) / s == (w - 3) / s);
            window_sums_q.push_back(beat);
        end

        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endtask

    task automatic check_result();
        t_conv_beat want;
        bit bad;

        bad = 0;
        if (window_sums_q.size() == 0) begin
            $error("result beat row %0d col %0d with no window pending",
                   i_out_row, i_out_col);
            o_fail_count++;
        end else begin
            want = window_sums_q.pop_front();
            if (i_conv_sum !== want.conv_sum) begin
                $error("conv_sum: expected %0d, actual %0d", want.conv_sum, i_conv_sum);
                bad = 1;
            end
            if (i_out_row !== want.out_row) begin
                $error("out_row: expected %0d, actual %0d", want.out_row, i_out_row);
                bad = 1;
            end
            if (i_out_col !== want.out_col) begin
                $error("out_col: expected %0d, actual %0d", want.out_col, i_out_col);
                bad = 1;
            end
            if (i_frame_last !== want.frame_last) begin
                $error("frame_last: expected %0d, actual %0d",
                       want.frame_last, i_frame_last);
                bad = 1;
            end
            if (bad)
                o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_sums_q.delete();
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                kernel_rows[i] = '0;
                for (int j = 0; j < KERNEL_SIZE; j++)
                    win[i][j] = '0;
            end
            stride_reg = STRIDE_W'(1);
            width_reg = DIM_W'(DEFAULT_DIM);
            height_reg = DIM_W'(DEFAULT_DIM);
            col_cnt = 0;
            row_cnt = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_KROW_TOP:   kernel_rows[0] = i_cfg_wdata;
                    REG_KROW_MID:   kernel_rows[1] = i_cfg_wdata;
                    REG_KROW_BOT:   kernel_rows[2] = i_cfg_wdata;
                    REG_STRIDE:     stride_reg = i_cfg_wdata[STRIDE_W-1:0];
                    REG_IMG_WIDTH:  width_reg = i_cfg_wdata[DIM_W-1:0];
                    REG_IMG_HEIGHT: height_reg = i_cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                slide_window(i_pixel);
            if (i_pop && !i_empty)
                check_result();
        end
        o_outstanding = window_sums_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import sc3_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 130;
    // sender never idles inside this span of pixels, the sink inside its own span
    localparam int SEND_BURST_LO = 150;
    localparam int SEND_BURST_HI = 350;
    localparam int SINK_BURST_LO = 50;
    localparam int SINK_BURST_HI = 110;
    localparam int HOLD_AT       = 8;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [7:0]        PIXEL_MIN    = 8'h80;
    localparam logic [7:0]        PIXEL_MAX    = 8'h7F;
    localparam logic [KROW_W-1:0] KROW_ALL_MIN = 24'h808080;
    localparam logic [KROW_W-1:0] KROW_ALL_MAX = 24'h7F7F7F;

    typedef enum {PX_RANDOM, PX_MIN, PX_MAX, PX_EXTREME} t_px_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    logic signed [7:0]      i_pixel;
    logic                   empty;
    logic                   pop;
    logic signed [SUM_W-1:0] o_conv_sum;
    logic [IDX_W-1:0]       o_out_row;
    logic [IDX_W-1:0]       o_out_col;
    logic                   o_frame_last;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [KROW_W-1:0]      i_cfg_wdata;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int sent_total = 0;

    strided_conv2d_3x3_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_pixel      (i_pixel),
        .empty        (empty),
        .pop          (pop),
        .o_conv_sum   (o_conv_sum),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    conv_window_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_pixel       (i_pixel),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_conv_sum    (o_conv_sum),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_frame_last  (o_frame_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // result sink: random stalls, one long hold-off so the core backs up
    initial begin : result_sink
        int  popped;
        bit  held;
        popped = 0;
        held = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                popped++;
            if (!held && popped == HOLD_AT) begin
                held = 1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pop <= (popped >= SINK_BURST_LO && popped < SINK_BURST_HI) ||
                   ($urandom_range(99) >= 30);
        end
    end

    function automatic logic [7:0] make_pixel(input t_px_mode mode);
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if (mode == PX_RANDOM && $urandom_range(7) != 0)
            return v;
        case (mode)
            PX_MIN: return PIXEL_MIN;
            PX_MAX: return PIXEL_MAX;
            default: begin
                case ($urandom_range(3))
                    0: v = PIXEL_MIN;
                    1: v = PIXEL_MAX;
                    2: v = 8'h00;
                    default: v = 8'hFF;
                endcase
                return v;
            end
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        logic [KROW_W-1:0] k;
        case ($urandom_range(7))
            0: k = KROW_ALL_MIN;
            1: k = KROW_ALL_MAX;
            default: k = KROW_W'($urandom());
        endcase
        return k;
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        while (!(sent_total >= SEND_BURST_LO && sent_total < SEND_BURST_HI) &&
               $urandom_range(99) < 30) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sent_total++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // all predicted windows out, then let pixels that close no window leave the pipe
    task automatic wait_idle();
        // wait on the clock first so the checker has taken the last pixel
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [KROW_W-1:0] k_top, input logic [KROW_W-1:0] k_mid,
                             input logic [KROW_W-1:0] k_bot, input logic [STRIDE_W-1:0] s,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int n, input t_px_mode mode);
        wait_idle();
        write_reg(REG_KROW_TOP, k_top);
        write_reg(REG_KROW_MID, k_mid);
        write_reg(REG_KROW_BOT, k_bot);
        write_reg(REG_STRIDE, KROW_W'(s));
        write_reg(REG_IMG_WIDTH, KROW_W'(w));
        write_reg(REG_IMG_HEIGHT, KROW_W'(h));
        i_cfg_wr_en <= 1'b0;
        for (int i = 0; i < n; i++)
            send_pixel(make_pixel(mode));
        push <= 1'b0;
    endtask

    initial begin : stimulus
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [STRIDE_W-1:0] s;
        t_px_mode            mode;
        int                  eff_w;
        int                  eff_h;
        int                  n;
        int                  random_sent;

        random_sent = 0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_pixel <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_KROW_TOP;
        i_cfg_wdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full frame as wide as any later width but the clamped one writes the line entries later windows read
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd1, 11'd24, 11'd4, 96, PX_RANDOM);
        // sum extremes
        run_phase(KROW_ALL_MIN, KROW_ALL_MIN, KROW_ALL_MIN, 3'd1, 11'd3, 11'd3, 9, PX_MIN);
        run_phase(KROW_ALL_MIN, KROW_ALL_MIN, KROW_ALL_MIN, 3'd1, 11'd3, 11'd3, 9, PX_MAX);
        run_phase(KROW_ALL_MAX, KROW_ALL_MAX, KROW_ALL_MAX, 3'd1, 11'd3, 11'd3, 18, PX_EXTREME);
        // stride zero acts as one
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd0, 11'd5, 11'd4, 40, PX_RANDOM);
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd4, 11'd7, 11'd7, 49, PX_EXTREME);
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd6, 11'd9, 11'd9, 81, PX_RANDOM);
        // stop mid-frame, then shrink: counters past the new size wrap to a new frame
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd2, 11'd8, 11'd6, 21, PX_RANDOM);
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd3, 11'd4, 11'd3, 24, PX_RANDOM);
        // oversized width clamps to the full line
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd1, 11'd2047, 11'd3, 30, PX_RANDOM);
        // tallest frame, width below range
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd1, 11'd0, 11'd1024, 30, PX_RANDOM);
        // height above range, stride beyond the nominal range
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd7, 11'd3, 11'd2047, 30, PX_RANDOM);
        run_phase(rand_krow(), rand_krow(), rand_krow(), 3'd5, 11'd12, 11'd0, 36, PX_RANDOM);

        while (random_sent < RANDOM_ITEMS) begin
            w = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(13, 24))
                                         : DIM_W'($urandom_range(3, 12));
            if ($urandom_range(15) == 0)
                w = DIM_W'($urandom_range(0, 2));
            h = DIM_W'($urandom_range(3, 6));
            if ($urandom_range(15) == 0)
                h = '0;
            s = ($urandom_range(4) == 0) ? STRIDE_W'($urandom_range(0, 7))
                                         : STRIDE_W'($urandom_range(1, 2));
            eff_w = (w < MIN_DIM) ? MIN_DIM : int'(w);
            eff_h = (h < MIN_DIM) ? MIN_DIM : int'(h);
            n = eff_w * eff_h * int'($urandom_range(1, 2));
            // now and then break off mid-frame
            if ($urandom_range(3) == 0)
                n = int'($urandom_range(1, n));
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            mode = PX_RANDOM;
            if ($urandom_range(5) == 0)
                mode = PX_EXTREME;
            run_phase(rand_krow(), rand_krow(), rand_krow(), s, w, h, n, mode);
            random_sent += n;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
